// ===== sv/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Request and response types, the heap entry layout and the priority
// comparison used by the queue modules.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// Request kinds.
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Width of the reported entry count.
	localparam int COUNT_W = 7;

	// One request as it arrives on the input channel.
	typedef struct packed {
		logic               req_type;
		logic signed [31:0] item_value;
		logic signed [31:0] item_priority;
	} req_t;

	// One response as it leaves on the output channel.
	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic signed [31:0] head_value;
		logic signed [31:0] head_priority;
	} rsp_t;

	// One heap entry: value in the upper half, priority in the lower half.
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	// True when entry a must be served before entry b.
	function automatic logic prio_less(input entry_t a, input entry_t b);
		return a.prio < b.prio;
	endfunction

endpackage

// ===== sv/mhpq_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap sift engine
// Holds the heap array and walks it one level at a time, sifting the new
// entry up on insert or the relocated last entry down on remove.
// ----------------------------------------------------------------------------
module mhpq_engine #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mhpq_pkg::req_t req,
	input  logic           rsp_free,
	output logic           idle,
	output logic           done,
	output mhpq_pkg::rsp_t rsp
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KW    = AW + 2;
	localparam int EW    = (CNT_W > mhpq_pkg::COUNT_W) ? CNT_W : mhpq_pkg::COUNT_W;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_UP_RD    = 9'b000000010,
		S_UP_CMP   = 9'b000000100,
		S_LAST_RD  = 9'b000001000,
		S_LAST_CAP = 9'b000010000,
		S_DN_RD    = 9'b000100000,
		S_DN_CMP   = 9'b001000000,
		S_HEAD_RD  = 9'b010000000,
		S_HEAD_CAP = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         kid_q;
	logic                  ok_q;
	mhpq_pkg::entry_t      cur_q;
	mhpq_pkg::entry_t      heap_mem_q [CAPACITY];
	mhpq_pkg::entry_t      rd_a_q;
	mhpq_pkg::entry_t      rd_b_q;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	mhpq_pkg::entry_t      wr_data;
	logic [AW-1:0]         rd_addr_a;
	logic [AW-1:0]         rd_addr_b;

	logic [AW-1:0]         parent_addr;
	logic [KW-1:0]         cnt_w;
	logic [KW-1:0]         kid_w;
	logic [KW-1:0]         right_w;
	logic [KW-1:0]         kid_right_w;
	logic                  has_kid;
	logic                  has_right;
	logic                  pick_right;
	mhpq_pkg::entry_t      child;
	logic [AW-1:0]         child_addr;
	logic                  up_move;
	logic                  dn_move;
	logic [EW-1:0]         cnt_ext;

	// Index arithmetic for the current level.
	assign parent_addr = AW'((pos_q - AW'(1)) >> 1);
	assign cnt_w       = KW'(cnt_q);
	assign kid_w       = (KW'(pos_q) << 1) + KW'(1);
	assign right_w     = kid_w + KW'(1);
	assign has_kid     = kid_w < cnt_w;
	assign kid_right_w = KW'(kid_q) + KW'(1);
	assign has_right   = kid_right_w < cnt_w;

	// Shared priority compare: the smaller child, then child against mover.
	assign pick_right = has_right && mhpq_pkg::prio_less(rd_b_q, rd_a_q);
	assign child      = pick_right ? rd_b_q : rd_a_q;
	assign child_addr = pick_right ? kid_right_w[AW-1:0] : kid_q;
	assign dn_move    = mhpq_pkg::prio_less(child, cur_q);
	assign up_move    = mhpq_pkg::prio_less(cur_q, rd_a_q);

	// Memory port control for each step of the sequencer.
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = cur_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		unique case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_addr_a = parent_addr;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (up_move) begin
					wr_data = rd_a_q;
				end
			end
			S_LAST_RD: begin
				rd_addr_a = cnt_q[AW-1:0];
			end
			S_DN_RD: begin
				if (has_kid) begin
					rd_addr_a = kid_w[AW-1:0];
					rd_addr_b = (right_w < cnt_w) ? right_w[AW-1:0] : kid_w[AW-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (dn_move) begin
					wr_data = child;
				end
			end
			S_IDLE, S_LAST_CAP, S_HEAD_RD, S_HEAD_CAP: begin
			end
			default: begin
			end
		endcase
	end

	// Heap array with one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= heap_mem_q[rd_addr_a];
		rd_b_q <= heap_mem_q[rd_addr_b];
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cur_q <= '{value: req.item_value, prio: req.item_priority};
					pos_q <= cnt_q[AW-1:0];
				end
			end
			S_UP_CMP: begin
				if (up_move) begin
					pos_q <= parent_addr;
				end
			end
			S_LAST_CAP: begin
				cur_q <= rd_a_q;
				pos_q <= '0;
			end
			S_DN_RD: begin
				kid_q <= kid_w[AW-1:0];
			end
			S_DN_CMP: begin
				if (dn_move) begin
					pos_q <= child_addr;
				end
			end
			S_UP_RD, S_LAST_RD, S_HEAD_RD, S_HEAD_CAP: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req.req_type == mhpq_pkg::REQ_INSERT) begin
							if (cnt_q != CNT_W'(CAPACITY)) begin
								cnt_q   <= cnt_q + CNT_W'(1);
								ok_q    <= 1'b1;
								state_q <= S_UP_RD;
							end else begin
								ok_q    <= 1'b0;
								state_q <= S_HEAD_RD;
							end
						end else begin
							if (cnt_q != '0) begin
								cnt_q   <= cnt_q - CNT_W'(1);
								ok_q    <= 1'b1;
								state_q <= (cnt_q == CNT_W'(1)) ? S_HEAD_RD : S_LAST_RD;
							end else begin
								ok_q    <= 1'b0;
								state_q <= S_HEAD_RD;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_HEAD_RD : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= up_move ? S_UP_RD : S_HEAD_RD;
				end
				S_LAST_RD: begin
					state_q <= S_LAST_CAP;
				end
				S_LAST_CAP: begin
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= has_kid ? S_DN_CMP : S_HEAD_RD;
				end
				S_DN_CMP: begin
					state_q <= dn_move ? S_DN_RD : S_HEAD_RD;
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_CAP;
				end
				S_HEAD_CAP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response built from the count and the root read back from the array.
	assign cnt_ext = EW'(cnt_q);

	always_comb begin
		rsp.ok          = ok_q;
		rsp.entry_count = cnt_ext[mhpq_pkg::COUNT_W-1:0];
		rsp.is_empty    = (cnt_q == '0);
		if (cnt_q == '0) begin
			rsp.head_value    = '0;
			rsp.head_priority = '0;
		end else begin
			rsp.head_value    = rd_a_q.value;
			rsp.head_priority = rd_a_q.prio;
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_HEAD_CAP) && rsp_free;

endmodule

// ===== sv/min_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// A refused request or the removal of the last entry goes straight to reading back the root;
// an insert first sifts the new entry up level by level until it reaches the root or stops
// below it, and a remove reads the last entry and sifts it down until it reaches a leaf or
// stops above one; the response is then registered from the count and the root.
// Throughput: one request at a time; the next is accepted once the engine is idle again after
// registering the response, and a held response stalls the engine.
// Reset: asynchronous, active low; clears the entry count and the handshake state.
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Binary min-heap of value and priority pairs with insert and remove-head
// requests; every request returns the heap state after the operation.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mhpq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mhpq_pkg::rsp_t rsp
);

	logic           eng_idle;
	logic           eng_done;
	logic           rsp_free;
	logic           rsp_valid_q;
	mhpq_pkg::rsp_t eng_rsp;
	mhpq_pkg::rsp_t rsp_q;

	assign req_ready = eng_idle;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	mhpq_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (req_valid && req_ready),
		.req     (req),
		.rsp_free(rsp_free),
		.idle    (eng_idle),
		.done    (eng_done),
		.rsp     (eng_rsp)
	);

	// Output register: the engine may take a new request while a response waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An accepted request keeps the engine busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("engine idle straight after accepting a request");

	// A finished response never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> (!rsp_valid_q || rsp_ready))
		else $error("response register overwritten");

	// An empty heap reports a zero count and a zero head.
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |->
			rsp.entry_count == '0 && rsp.head_value == '0 && rsp.head_priority == '0)
		else $error("empty heap reported with a count or head");

endmodule
